// ----- rtl/mmcs_pkg.sv -----
`default_nettype none
package mmcs_pkg;

	// sample format
	localparam int SAMPLE_BITS = 16;
	localparam int SAMPLE_W    = 16;
	// tracker values span both readings of a sample, so one extra bit
	localparam int VAL_W       = SAMPLE_BITS + 1;
	localparam int PIX_W       = 8;
	localparam int PROD_W      = VAL_W + PIX_W;

	// queue between front and back
	localparam int FIFO_DEPTH  = 2;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	// one divider step per quotient bit
	localparam int DIV_CNT_W   = $clog2(PIX_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(PIX_W - 1);

	// request codes
	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_SCALE   = 1'b1;

	// pixel extremes
	localparam logic [PIX_W-1:0] PIX_MIN = '0;
	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	// type extremes under each reading
	localparam logic signed [VAL_W-1:0] UNS_GREATEST = VAL_W'((64'd1 << SAMPLE_BITS) - 64'd1);
	localparam logic signed [VAL_W-1:0] UNS_LEAST    = '0;
	localparam logic signed [VAL_W-1:0] SGN_GREATEST =
		VAL_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [VAL_W-1:0] SGN_LEAST    =
		VAL_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	// one classified scale request
	typedef struct packed {
		logic               direct;
		logic [PIX_W-1:0]   pixel;
		logic [VAL_W-1:0]   num;
		logic [VAL_W-1:0]   delta;
		logic               last;
	} job_t;

	// queue status toward its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage
`default_nettype wire

// ----- rtl/mmcs_front.sv -----
`default_nettype none
module mmcs_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            op,
	input  wire logic [mmcs_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic                            last_in,
	input  wire mmcs_pkg::qstat_t                qstat,
	output logic                                 push,
	output mmcs_pkg::job_t                       job
);

	logic                                  samples_signed_q;
	logic signed [mmcs_pkg::VAL_W-1:0]     min_q;
	logic signed [mmcs_pkg::VAL_W-1:0]     max_q;
	logic                                  done_q;

	logic [mmcs_pkg::SAMPLE_BITS-1:0]      raw;
	logic signed [mmcs_pkg::VAL_W-1:0]     v;
	logic signed [mmcs_pkg::VAL_W-1:0]     greatest;
	logic signed [mmcs_pkg::VAL_W-1:0]     least;
	logic signed [mmcs_pkg::VAL_W-1:0]     base_min;
	logic signed [mmcs_pkg::VAL_W-1:0]     base_max;
	logic signed [mmcs_pkg::VAL_W:0]       num_d;
	logic signed [mmcs_pkg::VAL_W:0]       delta_d;
	logic                                  accept;

	// read the sample under the current signedness
	assign raw = sample[mmcs_pkg::SAMPLE_BITS-1:0];
	assign v   = samples_signed_q ? $signed({raw[mmcs_pkg::SAMPLE_BITS-1], raw})
	                              : $signed({1'b0, raw});

	assign greatest = samples_signed_q ? mmcs_pkg::SGN_GREATEST : mmcs_pkg::UNS_GREATEST;
	assign least    = samples_signed_q ? mmcs_pkg::SGN_LEAST    : mmcs_pkg::UNS_LEAST;

	// a new pass starts from the type extremes
	assign base_min = done_q ? greatest : min_q;
	assign base_max = done_q ? least    : max_q;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (op == mmcs_pkg::OP_SCALE);

	// classify a scale request: clamp cases resolve here, the rest go to the divider
	assign num_d   = $signed({v[mmcs_pkg::VAL_W-1], v}) - $signed({min_q[mmcs_pkg::VAL_W-1], min_q});
	assign delta_d = $signed({max_q[mmcs_pkg::VAL_W-1], max_q})
	               - $signed({min_q[mmcs_pkg::VAL_W-1], min_q});

	always_comb begin
		job.direct = 1'b1;
		job.pixel  = mmcs_pkg::PIX_MIN;
		job.num    = num_d[mmcs_pkg::VAL_W-1:0];
		job.delta  = delta_d[mmcs_pkg::VAL_W-1:0];
		job.last   = last_in;
		if (max_q <= min_q) begin
			// flat range
			job.pixel = (v <= 0) ? mmcs_pkg::PIX_MIN : mmcs_pkg::PIX_MAX;
		end else if (num_d <= 0) begin
			job.pixel = mmcs_pkg::PIX_MIN;
		end else if (num_d >= delta_d) begin
			job.pixel = mmcs_pkg::PIX_MAX;
		end else begin
			job.direct = 1'b0;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_signed_q <= 1'b0;
		end else if (cfg_we) begin
			samples_signed_q <= cfg_wdata;
		end
	end

	// running min and max trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= mmcs_pkg::UNS_GREATEST;
			max_q  <= mmcs_pkg::UNS_LEAST;
			done_q <= 1'b1;
		end else if (accept) begin
			if (op == mmcs_pkg::OP_MEASURE) begin
				min_q  <= (v < base_min) ? v : base_min;
				max_q  <= (v > base_max) ? v : base_max;
				done_q <= last_in;
			end else begin
				done_q <= 1'b1;
			end
		end
	end

	// after any measured sample the range is well formed
	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == mmcs_pkg::OP_MEASURE) |=> (max_q >= min_q))
		else $error("tracker range inverted after measure");

	// a request that reaches the divider lies strictly inside the range
	a_div_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !job.direct) |-> (job.num != '0 && job.num < job.delta))
		else $error("divider request outside open range");

endmodule
`default_nettype wire

// ----- rtl/mmcs_fifo.sv -----
`default_nettype none
module mmcs_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire mmcs_pkg::job_t     wdata,
	input  wire logic               pop,
	output mmcs_pkg::job_t          rdata,
	output mmcs_pkg::qstat_t        qstat
);

	mmcs_pkg::job_t                     mem [mmcs_pkg::FIFO_DEPTH];
	logic [mmcs_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [mmcs_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [mmcs_pkg::FIFO_CNT_W-1:0]    count_q;

	assign qstat.full  = (count_q == mmcs_pkg::FIFO_CNT_W'(mmcs_pkg::FIFO_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rdata       = mem[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == mmcs_pkg::FIFO_PTR_W'(mmcs_pkg::FIFO_DEPTH - 1))
				          ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == mmcs_pkg::FIFO_PTR_W'(mmcs_pkg::FIFO_DEPTH - 1))
				          ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!qstat.full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

endmodule
`default_nettype wire

// ----- rtl/mmcs_back.sv -----
`default_nettype none
module mmcs_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mmcs_pkg::qstat_t              qstat,
	input  wire mmcs_pkg::job_t                job,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mmcs_pkg::PIX_W-1:0]         pixel,
	output logic                               last_out
);

	mmcs_pkg::back_state_t                 state_q;
	mmcs_pkg::back_state_t                 state_d;
	logic [mmcs_pkg::VAL_W-1:0]            rem_q;
	logic [mmcs_pkg::VAL_W-1:0]            div_q;
	logic [mmcs_pkg::PIX_W-1:0]            low_q;
	logic [mmcs_pkg::PIX_W-1:0]            quo_q;
	logic [mmcs_pkg::DIV_CNT_W-1:0]        cnt_q;
	logic                                  last_q;
	logic                                  out_valid_q;
	logic [mmcs_pkg::PIX_W-1:0]            pixel_q;
	logic                                  last_out_q;

	logic                                  out_free;
	logic                                  load_direct;
	logic                                  load_div;
	logic                                  emit_div;
	logic [mmcs_pkg::PROD_W-1:0]           prod;
	logic [mmcs_pkg::VAL_W:0]              rem_sh;
	logic [mmcs_pkg::VAL_W:0]              trial;
	logic                                  fits;

	assign out_free = !out_valid_q || out_ready;

	// numerator times 255 as a shift and subtract
	assign prod = {job.num, mmcs_pkg::PIX_W'(0)} - mmcs_pkg::PROD_W'(job.num);

	// one restoring step
	assign rem_sh = {rem_q, low_q[mmcs_pkg::PIX_W-1]};
	assign trial  = rem_sh - {1'b0, div_q};
	assign fits   = !trial[mmcs_pkg::VAL_W];

	// next state and handshakes
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		load_direct = 1'b0;
		load_div    = 1'b0;
		emit_div    = 1'b0;
		case (state_q)
			mmcs_pkg::BK_IDLE: begin
				if (!qstat.empty) begin
					if (job.direct) begin
						if (out_free) begin
							pop         = 1'b1;
							load_direct = 1'b1;
						end
					end else begin
						pop      = 1'b1;
						load_div = 1'b1;
						state_d  = mmcs_pkg::BK_DIV;
					end
				end
			end
			mmcs_pkg::BK_DIV: begin
				if (cnt_q == mmcs_pkg::DIV_LAST_STEP) begin
					state_d = mmcs_pkg::BK_DONE;
				end
			end
			mmcs_pkg::BK_DONE: begin
				if (out_free) begin
					emit_div = 1'b1;
					state_d  = mmcs_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = mmcs_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmcs_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (load_div) begin
			rem_q  <= prod[mmcs_pkg::PROD_W-1:mmcs_pkg::PIX_W];
			low_q  <= prod[mmcs_pkg::PIX_W-1:0];
			div_q  <= job.delta;
			last_q <= job.last;
			quo_q  <= '0;
			cnt_q  <= '0;
		end else if (state_q == mmcs_pkg::BK_DIV) begin
			rem_q <= fits ? trial[mmcs_pkg::VAL_W-1:0] : rem_sh[mmcs_pkg::VAL_W-1:0];
			low_q <= {low_q[mmcs_pkg::PIX_W-2:0], 1'b0};
			quo_q <= {quo_q[mmcs_pkg::PIX_W-2:0], fits};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_direct || emit_div) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			pixel_q    <= job.pixel;
			last_out_q <= job.last;
		end else if (emit_div) begin
			pixel_q    <= quo_q;
			last_out_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel     = pixel_q;
	assign last_out  = last_out_q;

	// partial remainder never reaches the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mmcs_pkg::BK_DIV) |-> (rem_q < div_q))
		else $error("divider remainder out of bound");

	// a waiting result is never overwritten
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(load_direct || emit_div) |-> out_free)
		else $error("output register overwritten");

endmodule
`default_nettype wire

// ----- rtl/minmax_contrast_stretch_8bit_top.sv -----
// min/max contrast stretch of 16-bit samples to 8-bit pixels
// input channel in_valid/in_ready carries op, sample, last_in. a measure
// request (op 0) updates the running min and max and gives no result; the
// first one after a finished pass restarts the trackers. a scale request
// (op 1) gives one pixel floor((v-min)*255/(max-min)), clamped to 0..255,
// with last_out copied from last_in.
// cfg_we writes cfg_wdata into samples_signed (1 two's complement, 0 unsigned);
// write it only while no request is in flight.
// a measure request updates the trackers as it is accepted. a scale request
// is queued; a clamped or flat-range pixel then goes from the queue head to
// the output register once it is free, one per cycle while out_ready holds.
// a pixel inside the range first passes the 8-step restoring divider (one
// quotient bit per cycle), which takes no new request until it has finished.
// a two-entry queue sits between the classifying front and the divider, so
// measure requests keep flowing while the divider works; in_ready drops only
// when that queue is full. a stalled out_ready holds pixel in the output
// register and backs up through the queue.
// reset clears the trackers to min 65535, max 0, unsigned reading, and
// empties the queue and the output register.
`default_nettype none
module minmax_contrast_stretch_8bit_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            op,
	input  wire logic [mmcs_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic                            last_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [mmcs_pkg::PIX_W-1:0]           pixel,
	output logic                                 last_out
);

	mmcs_pkg::qstat_t   qstat;
	mmcs_pkg::job_t     push_job;
	mmcs_pkg::job_t     head_job;
	logic               push;
	logic               pop;

	// classify requests and track the range
	mmcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.sample    (sample),
		.last_in   (last_in),
		.qstat     (qstat),
		.push      (push),
		.job       (push_job)
	);

	// decoupling queue
	mmcs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_job),
		.pop    (pop),
		.rdata  (head_job),
		.qstat  (qstat)
	);

	// divide and deliver
	mmcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.job       (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel     (pixel),
		.last_out  (last_out)
	);

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 8;
	localparam int MAX_GAP        = 12;
	// extra wait after the last pixel so that the block settles
	localparam int SETTLE_CYCLES  = 16;
	localparam int RX_HOLD_CYCLES = 300;
	// no handshake for this long means the block is hung
	localparam int STALL_LIMIT    = 3000;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 120;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [mmcs_pkg::PIX_W-1:0] pixel;
		logic                       last;
	} expected_pixel_t;

	// tracks the running min/max and the pixels the block owes us
	class stretch_predictor;
		logic signed [mmcs_pkg::VAL_W-1:0] run_min;
		logic signed [mmcs_pkg::VAL_W-1:0] run_max;
		logic                              pass_closed;
		logic                              samples_signed;
		expected_pixel_t                   pending_pixels[$];
		int                                errors;
		int                                n_measure;
		int                                n_scale;
		int                                n_checked;

		function new();
			samples_signed = 1'b0;
			run_min        = mmcs_pkg::UNS_GREATEST;
			run_max        = mmcs_pkg::UNS_LEAST;
			pass_closed    = 1'b1;
			errors         = 0;
			n_measure      = 0;
			n_scale        = 0;
			n_checked      = 0;
		endfunction

		function logic signed [mmcs_pkg::VAL_W-1:0] type_greatest();
			return samples_signed ? mmcs_pkg::SGN_GREATEST : mmcs_pkg::UNS_GREATEST;
		endfunction

		function logic signed [mmcs_pkg::VAL_W-1:0] type_least();
			return samples_signed ? mmcs_pkg::SGN_LEAST : mmcs_pkg::UNS_LEAST;
		endfunction

		// sample bits as a number under the current reading
		function logic signed [mmcs_pkg::VAL_W-1:0] to_value(
				logic [mmcs_pkg::SAMPLE_W-1:0] raw);
			logic signed [mmcs_pkg::VAL_W-1:0] v;
			if (samples_signed)
				v = mmcs_pkg::VAL_W'($signed(raw));
			else
				v = $signed(mmcs_pkg::VAL_W'(raw));
			return v;
		endfunction

		// exact floor of the stretch ratio with clamping
		function logic [mmcs_pkg::PIX_W-1:0] stretch(logic signed [mmcs_pkg::VAL_W-1:0] v);
			longint span;
			longint offs;
			if (run_max <= run_min)
				return (v <= 0) ? mmcs_pkg::PIX_MIN : mmcs_pkg::PIX_MAX;
			span = longint'(run_max) - longint'(run_min);
			offs = longint'(v) - longint'(run_min);
			if (offs <= 0)
				return mmcs_pkg::PIX_MIN;
			if (offs >= span)
				return mmcs_pkg::PIX_MAX;
			return mmcs_pkg::PIX_W'((offs * longint'(mmcs_pkg::PIX_MAX)) / span);
		endfunction

		function void note_request(logic o, logic [mmcs_pkg::SAMPLE_W-1:0] raw, logic l);
			logic signed [mmcs_pkg::VAL_W-1:0] v;
			expected_pixel_t                   next_px;
			v = to_value(raw);
			if (o == mmcs_pkg::OP_MEASURE) begin
				n_measure++;
				// first measure after a finished pass restarts the trackers
				if (pass_closed) begin
					run_min     = type_greatest();
					run_max     = type_least();
					pass_closed = 1'b0;
				end
				if (v > run_max)
					run_max = v;
				if (v < run_min)
					run_min = v;
				if (l)
					pass_closed = 1'b1;
			end else begin
				n_scale++;
				pass_closed   = 1'b1;
				next_px.pixel = stretch(v);
				next_px.last  = l;
				pending_pixels.insert(pending_pixels.size(), next_px);
			end
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("[%0t] mismatch %0d: %s", $realtime, errors, msg);
		endfunction

		function void check_pixel(logic [mmcs_pkg::PIX_W-1:0] p, logic l);
			expected_pixel_t exp_px;
			if (pending_pixels.size() == 0) begin
				report($sformatf("pixel %0d last %0b with no pending request", p, l));
				return;
			end
			exp_px = pending_pixels.pop_front();
			n_checked++;
			if (exp_px.pixel !== p || exp_px.last !== l)
				report($sformatf("expected pixel %0d last %0b, got pixel %0d last %0b",
					exp_px.pixel, exp_px.last, p, l));
		endfunction
	endclass

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic                          cfg_wdata = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic                          op        = mmcs_pkg::OP_MEASURE;
	logic [mmcs_pkg::SAMPLE_W-1:0] sample    = '0;
	logic                          last_in   = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [mmcs_pkg::PIX_W-1:0]    pixel;
	logic                          last_out;

	stretch_predictor sb = new();

	bit tx_idle_on  = 1'b1;
	bit rx_idle_on  = 1'b1;
	int rx_hold_len = 0;
	int quiet_cycles = 0;

	minmax_contrast_stretch_8bit_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.sample   (sample),
		.last_in  (last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel    (pixel),
		.last_out (last_out)
	);

	// clock
	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// predict on every accepted request, check every accepted pixel
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_request(op, sample, last_in);
		if (out_valid && out_ready)
			sb.check_pixel(pixel, last_out);
	end

	// hang detection
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[%0t] timeout: no handshake for %0d cycles", $realtime, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// output side: random stalls per pixel, or one long hold when asked
	initial begin : pixel_sink
		int wait_cycles;
		forever begin
			if (rx_hold_len > 0) begin
				wait_cycles = rx_hold_len;
				rx_hold_len = 0;
			end else begin
				wait_cycles = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// offer one request and hold it until taken
	task automatic send_request(input logic o, input logic [mmcs_pkg::SAMPLE_W-1:0] s,
			input logic l);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		sample   <= s;
		last_in  <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// stop sending until every pixel is back and the block is quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_signedness(input logic value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.samples_signed = value;
	endtask

	// mostly near the pass range, sometimes extremes or full random bits
	function automatic logic [mmcs_pkg::SAMPLE_W-1:0] gen_sample(
			logic [mmcs_pkg::SAMPLE_W-1:0] base, int span);
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'h0000;
					1: return 16'hFFFF;
					2: return 16'h7FFF;
					default: return 16'h8000;
				endcase
			end
			1: return mmcs_pkg::SAMPLE_W'($urandom);
			default: return base + mmcs_pkg::SAMPLE_W'($urandom_range(0, span));
		endcase
	endfunction

	initial begin : stimulus
		int                            phase_items;
		int                            nm;
		int                            ns;
		int                            span;
		logic [mmcs_pkg::SAMPLE_W-1:0] base;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scale before any measure: flat range at reset extremes
		send_request(mmcs_pkg::OP_SCALE, 16'h0000, 1'b0);
		send_request(mmcs_pkg::OP_SCALE, 16'h0001, 1'b0);
		send_request(mmcs_pkg::OP_SCALE, 16'hFFFF, 1'b1);

		// unsigned pass, then below, at, inside and above the range
		send_request(mmcs_pkg::OP_MEASURE, 16'd100, 1'b0);
		send_request(mmcs_pkg::OP_MEASURE, 16'd1000, 1'b1);
		send_request(mmcs_pkg::OP_SCALE, 16'd50, 1'b0);
		send_request(mmcs_pkg::OP_SCALE, 16'd100, 1'b0);
		send_request(mmcs_pkg::OP_SCALE, 16'd550, 1'b0);
		send_request(mmcs_pkg::OP_SCALE, 16'd999, 1'b0);
		send_request(mmcs_pkg::OP_SCALE, 16'd1000, 1'b0);
		send_request(mmcs_pkg::OP_SCALE, 16'hFFFF, 1'b1);

		// pass with no last, cut off by a scale; next measure starts fresh
		send_request(mmcs_pkg::OP_MEASURE, 16'h0000, 1'b0);
		send_request(mmcs_pkg::OP_MEASURE, 16'hFFFF, 1'b0);
		send_request(mmcs_pkg::OP_SCALE, 16'h8000, 1'b0);
		send_request(mmcs_pkg::OP_MEASURE, 16'd5, 1'b1);
		// single-value range: flat rule
		send_request(mmcs_pkg::OP_SCALE, 16'd5, 1'b0);
		send_request(mmcs_pkg::OP_SCALE, 16'd0, 1'b1);

		// two's complement extremes
		settle_block();
		write_signedness(1'b1);
		send_request(mmcs_pkg::OP_MEASURE, 16'h8000, 1'b0);
		send_request(mmcs_pkg::OP_MEASURE, 16'h7FFF, 1'b1);
		send_request(mmcs_pkg::OP_SCALE, 16'hFFFF, 1'b0);
		send_request(mmcs_pkg::OP_SCALE, 16'h0000, 1'b1);

		// reading switched in the middle of a measure pass
		send_request(mmcs_pkg::OP_MEASURE, 16'hFFFF, 1'b0);
		settle_block();
		write_signedness(1'b0);
		send_request(mmcs_pkg::OP_MEASURE, 16'h0010, 1'b1);
		send_request(mmcs_pkg::OP_SCALE, 16'hFFFF, 1'b0);
		send_request(mmcs_pkg::OP_SCALE, 16'h0005, 1'b1);

		// random phases, one setting of the reading each
		for (int phase = 0; phase < PHASES; phase++) begin
			settle_block();
			write_signedness(phase < 4 ? logic'(phase % 2) : logic'($urandom_range(0, 1)));

			// long output hold while the input keeps pushing scale requests
			if (phase == 2) begin
				tx_idle_on  = 1'b0;
				rx_hold_len = RX_HOLD_CYCLES;
				send_request(mmcs_pkg::OP_MEASURE, 16'h1000, 1'b0);
				send_request(mmcs_pkg::OP_MEASURE, 16'h9000, 1'b1);
				for (int k = 0; k < 24; k++)
					send_request(mmcs_pkg::OP_SCALE, gen_sample(16'h0F00, 16'h8400),
						k == 23);
				settle_block();
			end

			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if (phase == 3) begin
					tx_idle_on = 1'b0;
					rx_idle_on = 1'b0;
				end else begin
					tx_idle_on = ($urandom_range(0, 5) != 0);
					rx_idle_on = ($urandom_range(0, 5) != 0);
				end
				base = mmcs_pkg::SAMPLE_W'($urandom);
				span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 400);
				case ($urandom_range(0, 9))
					8: begin
						// noise
						nm = $urandom_range(1, 6);
						for (int k = 0; k < nm; k++)
							send_request(logic'($urandom_range(0, 1)),
								mmcs_pkg::SAMPLE_W'($urandom),
								logic'($urandom_range(0, 1)));
						phase_items += nm;
					end
					9: begin
						// measure pass cut off without last
						nm = $urandom_range(1, 5);
						ns = $urandom_range(1, 4);
						for (int k = 0; k < nm; k++)
							send_request(mmcs_pkg::OP_MEASURE, gen_sample(base, span), 1'b0);
						for (int k = 0; k < ns; k++)
							send_request(mmcs_pkg::OP_SCALE,
								gen_sample(base - 16'd16, span + 32),
								logic'($urandom_range(0, 1)));
						phase_items += nm + ns;
					end
					default: begin
						// well-formed measure pass then scale pass
						nm = $urandom_range(1, 10);
						ns = $urandom_range(1, 10);
						for (int k = 0; k < nm; k++)
							send_request(mmcs_pkg::OP_MEASURE, gen_sample(base, span),
								k == nm - 1);
						for (int k = 0; k < ns; k++)
							send_request(mmcs_pkg::OP_SCALE,
								gen_sample(base - 16'd16, span + 32), k == ns - 1);
						phase_items += nm + ns;
					end
				endcase
			end
		end

		// drain and close out
		settle_block();
		if (sb.pending_pixels.size() != 0) begin
			sb.report($sformatf("%0d pixels never arrived", sb.pending_pixels.size()));
		end
		$display("run covered %0d measure and %0d scale requests, %0d pixels checked",
			sb.n_measure, sb.n_scale, sb.n_checked);
		$display("both sample readings, a mid-pass reading change, a long output hold");
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/mmcs_pkg.sv
rtl/mmcs_front.sv
rtl/mmcs_fifo.sv
rtl/mmcs_back.sv
rtl/minmax_contrast_stretch_8bit_top.sv
tb/testbench.sv
